/* hw/rtl/ccp_pkg.sv */
package ccp_pkg;

    localparam logic [7:0] REG_HALF_LENGTH = 8'd0;
    localparam logic [7:0] REG_CAP_RADIUS  = 8'd1;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 63;
    localparam int LANES      = 3;

    typedef struct packed {
        logic signed [31:0]         x;
        logic signed [31:0]         axis_pt;
        logic                       is_in;
        logic                       all_in;
        logic                       nz;
        logic [LANES-1:0]           sgn;
        logic [LANES-1:0][31:0]     mg;
    } side_t;

    typedef struct packed {
        side_t        side;
        logic [33:0]  rem;
        logic [31:0]  root;
        logic [63:0]  n;
    } sqrt_t;

    typedef struct packed {
        side_t                  side;
        logic [31:0]            s;
        logic [LANES-1:0][31:0] rem;
        logic [LANES-1:0][62:0] nq;
    } div_t;

endpackage

/* hw/rtl/capsule_containment_projection.sv */
// Projects a point onto a capsule centred on the x axis and reports whether
// the point, and a sphere of the given margin around it, lies inside. The
// pipeline takes one beat per cycle unless the output stalls. Each beat
// passes the input, square and sum registers, 32 square-root stages, the
// multiply register, 63 stages of three parallel dividers and the output
// register. A stalled output beat holds the pipeline and stalls the input.
module capsule_containment_projection #(
    parameter int DIMENSIONS    = 3,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [30:0]        margin,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_inside,
    output logic               all_inside,
    output logic signed [31:0] proj_x,
    output logic signed [31:0] proj_y,
    output logic signed [31:0] proj_z
);

    localparam int NS = ccp_pkg::SQRT_STEPS;
    localparam int ND = ccp_pkg::DIV_STEPS;
    localparam int NL = ccp_pkg::LANES;

    logic [30:0] hl_reg;
    logic [30:0] rad_reg;
    logic        adv;

    logic               a_vld_reg;
    logic signed [31:0] a_x_reg;
    logic signed [31:0] a_y_reg;
    logic signed [31:0] a_z_reg;
    logic [30:0]        a_m_reg;

    logic        b_vld_reg;
    logic [63:0] b_y2_reg, b_z2_reg, b_d2_reg, b_r2_reg, b_m2_reg;
    logic [63:0] b_y2_next, b_z2_next, b_d2_next, b_r2_next, b_m2_next;
    ccp_pkg::side_t b_side_reg, b_side_next;

    logic        c_vld_reg;
    logic [63:0] c_nrm_reg, c_r2_reg, c_m2_reg;
    ccp_pkg::side_t c_side_reg;

    logic [NS-1:0]  sq_vld_reg;
    ccp_pkg::sqrt_t sq_reg  [NS];
    ccp_pkg::sqrt_t sq_next [NS];

    logic           mu_vld_reg;
    logic [31:0]    mu_s_reg;
    logic [NL-1:0][62:0] mu_p_reg;
    ccp_pkg::side_t mu_side_reg;

    logic [ND-1:0]  dv_vld_reg;
    ccp_pkg::div_t  dv_reg  [ND];
    ccp_pkg::div_t  dv_next [ND];

    logic               o_vld_reg;
    logic               o_in_reg, o_all_reg;
    logic signed [31:0] o_x_reg, o_y_reg, o_z_reg;
    logic signed [31:0] o_x_next, o_y_next, o_z_next;

    function automatic ccp_pkg::sqrt_t sqrt_step(input ccp_pkg::sqrt_t st);
        ccp_pkg::sqrt_t r;
        logic [35:0]    rem2;
        logic [35:0]    trial;
        r     = st;
        rem2  = {st.rem, st.n[63:62]};
        trial = {2'b00, st.root, 2'b01};
        if (rem2 >= trial)
        begin
            r.rem  = 34'(rem2 - trial);
            r.root = {st.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2[33:0];
            r.root = {st.root[30:0], 1'b0};
        end
        r.n = {st.n[61:0], 2'b00};
        return r;
    endfunction

    function automatic ccp_pkg::div_t div_step(input ccp_pkg::div_t st);
        ccp_pkg::div_t r;
        logic [32:0]   rem2;
        logic          ge;
        r = st;
        for (int i = 0; i < NL; i++)
        begin
            rem2     = {st.rem[i], st.nq[i][62]};
            ge       = rem2 >= {1'b0, st.s};
            r.rem[i] = ge ? 32'(rem2 - {1'b0, st.s}) : rem2[31:0];
            r.nq[i]  = {st.nq[i][61:0], ge};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [64:0] v);
        logic [31:0] r;
        if (v > 65'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -65'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    assign cfg_ready = 1'b1;
    assign adv       = !(o_vld_reg && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_reg  <= '0;
            rad_reg <= 31'(64'd1 << FRACTION_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ccp_pkg::REG_HALF_LENGTH)
                hl_reg <= cfg_data[30:0];
            else if (cfg_index == ccp_pkg::REG_CAP_RADIUS)
                rad_reg <= cfg_data[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            sq_vld_reg <= '0;
            mu_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            o_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg  <= in_valid;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            sq_vld_reg <= {sq_vld_reg[NS-2:0], c_vld_reg};
            mu_vld_reg <= sq_vld_reg[NS-1];
            dv_vld_reg <= {dv_vld_reg[ND-2:0], mu_vld_reg};
            o_vld_reg  <= dv_vld_reg[ND-1];
        end
    end

    always_comb
    begin
        logic [31:0] ax, ay, az, dxm, rmm;
        logic [32:0] rm;
        logic        outside;
        ax      = mag32(a_x_reg);
        ay      = mag32(a_y_reg);
        az      = mag32(a_z_reg);
        outside = ax > {1'b0, hl_reg};
        dxm     = outside ? ax - {1'b0, hl_reg} : 32'd0;
        rm      = {2'b00, rad_reg} - {2'b00, a_m_reg};
        rmm     = rm[32] ? 32'(33'd0 - rm) : rm[31:0];

        b_y2_next = 64'(ay) * 64'(ay);
        b_z2_next = 64'(az) * 64'(az);
        b_d2_next = 64'(dxm) * 64'(dxm);
        b_r2_next = {33'd0, rad_reg} * {33'd0, rad_reg};
        b_m2_next = 64'(rmm) * 64'(rmm);

        b_side_next.x       = a_x_reg;
        b_side_next.axis_pt = outside ? (a_x_reg[31] ? 32'd0 - {1'b0, hl_reg}
                                                     : {1'b0, hl_reg})
                                      : a_x_reg;
        b_side_next.is_in   = 1'b0;
        b_side_next.all_in  = 1'b0;
        b_side_next.nz      = 1'b0;
        b_side_next.sgn     = {a_z_reg[31], a_y_reg[31], a_x_reg[31]};
        b_side_next.mg      = {az, ay, dxm};
    end

    always_comb
    begin
        ccp_pkg::sqrt_t st;
        st.side        = c_side_reg;
        st.side.is_in  = c_nrm_reg <= c_r2_reg;
        st.side.all_in = c_nrm_reg <= c_m2_reg;
        st.side.nz     = c_nrm_reg != 64'd0;
        st.rem         = '0;
        st.root        = '0;
        st.n           = c_nrm_reg;
        sq_next[0]     = sqrt_step(st);
        for (int i = 1; i < NS; i++)
            sq_next[i] = sqrt_step(sq_reg[i-1]);
    end

    always_comb
    begin
        ccp_pkg::div_t st;
        st.side    = mu_side_reg;
        st.s       = mu_s_reg;
        st.rem     = '0;
        st.nq      = mu_p_reg;
        dv_next[0] = div_step(st);
        for (int i = 1; i < ND; i++)
            dv_next[i] = div_step(dv_reg[i-1]);
    end

    always_comb
    begin
        ccp_pkg::div_t      d;
        logic signed [64:0] q [NL];
        d = dv_reg[ND-1];
        for (int i = 0; i < NL; i++)
            q[i] = d.side.sgn[i] ? 65'sd0 - $signed({2'b00, d.side.mg[i] == 32'd0 ? 63'd0
                                                             : d.nq[i]})
                                 : $signed({2'b00, d.nq[i]});
        if (d.side.nz)
        begin
            o_x_next = sat32(65'($signed(d.side.axis_pt)) + q[0]);
            o_y_next = sat32(q[1]);
            o_z_next = (DIMENSIONS == 2) ? 32'd0 : sat32(q[2]);
        end
        else
        begin
            o_x_next = d.side.x;
            o_y_next = {1'b0, rad_reg};
            o_z_next = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg <= pos_x;
            a_y_reg <= pos_y;
            a_z_reg <= (DIMENSIONS == 2) ? 32'sd0 : pos_z;
            a_m_reg <= margin;

            b_y2_reg   <= b_y2_next;
            b_z2_reg   <= b_z2_next;
            b_d2_reg   <= b_d2_next;
            b_r2_reg   <= b_r2_next;
            b_m2_reg   <= b_m2_next;
            b_side_reg <= b_side_next;

            c_nrm_reg  <= b_y2_reg + b_z2_reg + b_d2_reg;
            c_r2_reg   <= b_r2_reg;
            c_m2_reg   <= b_m2_reg;
            c_side_reg <= b_side_reg;

            for (int i = 0; i < NS; i++)
                sq_reg[i] <= sq_next[i];

            mu_s_reg    <= sq_reg[NS-1].root;
            mu_side_reg <= sq_reg[NS-1].side;
            for (int i = 0; i < NL; i++)
                mu_p_reg[i] <= 63'(sq_reg[NS-1].side.mg[i]) * 63'({1'b0, rad_reg});

            for (int i = 0; i < ND; i++)
                dv_reg[i] <= dv_next[i];

            o_in_reg  <= dv_reg[ND-1].side.is_in;
            o_all_reg <= dv_reg[ND-1].side.all_in;
            o_x_reg   <= o_x_next;
            o_y_reg   <= o_y_next;
            o_z_reg   <= o_z_next;
        end
    end

    assign out_valid  = o_vld_reg;
    assign is_inside  = o_in_reg;
    assign all_inside = o_all_reg;
    assign proj_x     = o_x_reg;
    assign proj_y     = o_y_reg;
    assign proj_z     = o_z_reg;

endmodule

/* hw/rtl/ccp_checker.sv */
module ccp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               is_inside,
    input logic signed [31:0] proj_x,
    input logic signed [31:0] proj_y
);

    // The pipeline only holds its input when a finished beat waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting output beat");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(proj_x) && $stable(proj_y)
                                      && $stable(is_inside)))
        else $error("stalled output beat changed");

endmodule

bind capsule_containment_projection ccp_checker u_ccp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_inside (is_inside),
    .proj_x    (proj_x),
    .proj_y    (proj_y)
);

/* test/tb_capsule_containment_projection.sv */
`timescale 1ns / 100ps

module tb_capsule_containment_projection;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        m;
    } point_t;

    typedef struct packed {
        logic               in_caps;
        logic               all_in;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } proj_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        margin;
    logic               out_valid;
    logic               out_stall;
    logic               is_inside;
    logic               all_inside;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;

    capsule_containment_projection u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .margin(margin),
        .out_valid(out_valid), .out_stall(out_stall),
        .is_inside(is_inside), .all_inside(all_inside),
        .proj_x(proj_x), .proj_y(proj_y), .proj_z(proj_z)
    );

    logic [30:0] half_len;
    logic [30:0] radius;
    point_t      pending_points[$];
    proj_t       expected_projs[$];
    int          errors;
    int          sent;
    int          checked;
    int          hold_off;
    bit          hold_req;
    bit          drv_gap_on;
    int          drv_wait;
    int          mon_wait;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] sq64(input logic signed [63:0] v);
        logic [63:0] a;
        a = abs64(v);
        return a * a;
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= r + bt)
            begin
                n = n - (r + bt);
                r = (r >> 1) + bt;
            end
            else
                r = r >> 1;
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] stretch(input logic signed [63:0] d,
                                                   input logic [63:0] s);
        logic [63:0] q;
        q = (abs64(d) * {33'd0, radius}) / s;
        return d < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic proj_t project_point(input point_t p);
        logic signed [63:0] x, y, z, len, rad, ap, dx, px, py, pz;
        logic [63:0]        nrm, ax, s;
        proj_t              r;
        x = p.x;
        y = p.y;
        z = p.z;
        len = {33'd0, half_len};
        rad = {33'd0, radius};
        nrm = sum_sat(sq64(y), sq64(z));
        ax = abs64(x);
        if (ax > len) nrm = sum_sat(nrm, sq64(ax - len));
        r.in_caps = nrm <= sq64(rad);
        r.all_in = nrm <= sq64(rad - $signed({33'd0, p.m}));
        if (x > len)
        begin
            ap = len;
            dx = x - len;
        end
        else if (x < -len)
        begin
            ap = -len;
            dx = x + len;
        end
        else
        begin
            ap = x;
            dx = 0;
        end
        if (nrm > 0)
        begin
            s = root64(nrm);
            px = ap + stretch(dx, s);
            py = stretch(y, s);
            pz = stretch(z, s);
        end
        else
        begin
            px = x;
            py = rad;
            pz = 0;
        end
        r.px = clip32(px);
        r.py = clip32(py);
        r.pz = clip32(pz);
        return r;
    endfunction

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            2: return $signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000;
            3: return 0;
            4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        endcase
    endfunction

    function automatic point_t rnd_point();
        point_t p;
        p.x = rnd_coord();
        p.y = $urandom_range(0, 7) == 0 ? 32'sd0 : rnd_coord();
        p.z = $urandom_range(0, 7) == 0 ? 32'sd0 : rnd_coord();
        case ($urandom_range(0, 3))
            0: p.m = $urandom;
            1: p.m = $urandom_range(0, 32'h0004_0000);
            2: p.m = 0;
            default: p.m = radius + $urandom_range(0, 3) - 1;
        endcase
        return p;
    endfunction

    task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic [30:0] m);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.m = m;
        pending_points.push_back(p);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ccp_pkg::REG_HALF_LENGTH)
            half_len = val[30:0];
        else
            radius = val[30:0];
    endtask

    task automatic drain();
        while (pending_points.size() != 0 || expected_projs.size() != 0 || in_valid)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            margin <= '0;
            drv_wait = 0;
        end
        else if (in_valid && in_stall)
        begin
        end
        else
        begin
            if (in_valid)
            begin
                expected_projs.push_back(project_point({pos_x, pos_y, pos_z, margin}));
                sent++;
            end
            if (drv_wait > 0)
            begin
                drv_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_points.size() != 0)
            begin
                point_t p;
                p = pending_points.pop_front();
                pos_x <= p.x;
                pos_y <= p.y;
                pos_z <= p.z;
                margin <= p.m;
                in_valid <= 1'b1;
                drv_wait = drv_gap_on && $urandom_range(0, 2) == 0 ? $urandom_range(0, 10) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mon_wait = 0;
            hold_off = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_projs.size() == 0)
                begin
                    $error("unexpected result beat");
                    errors++;
                end
                else
                begin
                    proj_t e;
                    e = expected_projs.pop_front();
                    checked++;
                    if (is_inside !== e.in_caps)
                    begin
                        $error("is_inside expected %0d got %0d", e.in_caps, is_inside);
                        errors++;
                    end
                    if (all_inside !== e.all_in)
                    begin
                        $error("all_inside expected %0d got %0d", e.all_in, all_inside);
                        errors++;
                    end
                    if (proj_x !== e.px)
                    begin
                        $error("proj_x expected %0d got %0d", e.px, proj_x);
                        errors++;
                    end
                    if (proj_y !== e.py)
                    begin
                        $error("proj_y expected %0d got %0d", e.py, proj_y);
                        errors++;
                    end
                    if (proj_z !== e.pz)
                    begin
                        $error("proj_z expected %0d got %0d", e.pz, proj_z);
                        errors++;
                    end
                end
                if (drv_gap_on && $urandom_range(0, 2) == 0)
                    mon_wait = $urandom_range(0, 10);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_off = 400;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1'b1;
            end
            else if (mon_wait > 0)
            begin
                mon_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("** capsule_containment_projection: FAILED **");
        $finish;
    end

    initial
    begin
        logic [31:0] lens[4];
        logic [31:0] rads[4];
        errors = 0;
        sent = 0;
        checked = 0;
        hold_req = 1'b0;
        drv_gap_on = 1'b0;
        half_len = 0;
        radius = 31'h0001_0000;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_point(0, 0, 0, 0);
        add_point(32'sh0000_8000, 0, 0, 0);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
        add_point(32'sh0002_0000, 0, 0, 0);
        add_point(0, 32'sh0000_8000, 32'shFFFF_8000, 32'h0000_4000);
        add_point(0, 32'sh0001_0000, 0, 31'h0001_0000);
        add_point(0, 32'sh0000_4000, 0, 31'h0002_0000);
        add_point(32'shFFFF_FFFF, 32'shFFFF_FFFF, 1, 1);
        drain();

        write_reg(ccp_pkg::REG_HALF_LENGTH, 32'h0003_0000);
        write_reg(ccp_pkg::REG_CAP_RADIUS, 32'h0000_8000);
        add_point(32'sh0001_0000, 0, 0, 0);
        add_point(32'sh0003_0000, 0, 0, 0);
        add_point(32'shFFFC_0000, 0, 0, 31'h0000_4000);
        add_point(32'sh0003_8000, 32'sh0000_8000, 0, 0);
        add_point(32'sh0002_0000, 32'sh0000_7FFF, 32'sh0000_0001, 31'h0000_8001);
        add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
        drain();

        lens[0] = 32'h7FFF_FFFF;
        rads[0] = 32'h7FFF_FFFF;
        lens[1] = 32'h0000_0000;
        rads[1] = 32'h0000_0000;
        lens[2] = 32'h0002_0000;
        rads[2] = 32'h0001_8000;
        lens[3] = 32'h0000_8000;
        rads[3] = 32'h0000_0001;
        drv_gap_on = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(ccp_pkg::REG_HALF_LENGTH, lens[ph]);
            write_reg(ccp_pkg::REG_CAP_RADIUS, rads[ph]);
            for (int i = 0; i < 40; i++)
                pending_points.push_back(rnd_point());
            drain();
        end

        write_reg(ccp_pkg::REG_HALF_LENGTH, 32'h0001_0000);
        write_reg(ccp_pkg::REG_CAP_RADIUS, 32'h0002_0000);
        drv_gap_on = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 300; i++)
            pending_points.push_back(rnd_point());
        drv_gap_on = 1'b1;
        drain();
        for (int i = 0; i < 200; i++)
        begin
            if (i % 50 == 0)
            begin
                write_reg(ccp_pkg::REG_HALF_LENGTH, $urandom_range(0, 32'h0008_0000));
                write_reg(ccp_pkg::REG_CAP_RADIUS, $urandom_range(0, 32'h0004_0000));
            end
            pending_points.push_back(rnd_point());
            if (i % 50 == 49)
                drain();
        end
        drain();

        $display("Covered %0d point queries, %0d results checked, under several capsule shapes",
                 sent, checked);
        $display("including the extremes, long output hold-offs and random idle gaps.");
        if (errors == 0)
            $display("** capsule_containment_projection: PASSED **");
        else
            $display("** capsule_containment_projection: FAILED **");
        $finish;
    end
endmodule
